>>> sv/bse_pkg.sv
// Shared constants, operation codes and state type of the bitmap search engine.
package bse_pkg;

	localparam int MAX_BITS_DEF  = 4096;
	localparam int WORD_BITS_DEF = 64;
	localparam int CNT_W         = 13;
	localparam int OP_W          = 4;
	localparam int COUNT_RESET   = 4096;

	localparam logic [OP_W-1:0] OP_SET    = 4'd0;
	localparam logic [OP_W-1:0] OP_CLR    = 4'd1;
	localparam logic [OP_W-1:0] OP_CHK    = 4'd2;
	localparam logic [OP_W-1:0] OP_NEXT1  = 4'd3;
	localparam logic [OP_W-1:0] OP_NEXT0  = 4'd4;
	localparam logic [OP_W-1:0] OP_FIRST1 = 4'd5;
	localparam logic [OP_W-1:0] OP_FIRST0 = 4'd6;
	localparam logic [OP_W-1:0] OP_LAST1  = 4'd7;
	localparam logic [OP_W-1:0] OP_SETALL = 4'd8;
	localparam logic [OP_W-1:0] OP_CLRALL = 4'd9;
	localparam logic [OP_W-1:0] OP_SHR    = 4'd10;
	localparam logic [OP_W-1:0] OP_SHL    = 4'd11;

	// range of codes with no operation behind them
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd12;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_BIT  = 7'b0000100,
		S_SRCH = 7'b0001000,
		S_LAST = 7'b0010000,
		S_STRM = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

endpackage

>>> sv/bse_ifs.sv
// Handshake interfaces for the request, response and configuration channels.
interface bse_req_if import bse_pkg::*;;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	logic [CNT_W-1:0] position;
	logic [CNT_W-1:0] amount;
	modport source (output valid, op, position, amount, input ready);
	modport sink (input valid, op, position, amount, output ready);
endinterface

interface bse_rsp_if import bse_pkg::*;;
	logic             valid;
	logic             ready;
	logic             ok;
	logic             bit_value;
	logic [CNT_W-1:0] found_index;
	modport source (output valid, ok, bit_value, found_index, input ready);
	modport sink (input valid, ok, bit_value, found_index, output ready);
endinterface

interface bse_cfg_if import bse_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> sv/bse_mem.sv
// Word store of the bitmap: one write port, one read port with registered data.
module bse_mem import bse_pkg::*; #(
	parameter int WORDS = 64,
	parameter int WIDTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [WORDS];

	// write one word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read one word, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/bse_seq.sv
// Operation sequencer: walks the word store for bit ops, searches, fills and shifts.
module bse_seq import bse_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [OP_W-1:0]      op,
	input  logic [CNT_W-1:0]     position,
	input  logic [CNT_W-1:0]     amount,
	input  logic [CNT_W-1:0]     n,
	output logic                 idle,
	output logic                 done,
	input  logic                 take,
	output logic                 ok,
	output logic                 bit_value,
	output logic [CNT_W-1:0]     found_index,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [WORD_BITS-1:0] wr_data,
	input  logic [WORD_BITS-1:0] rd_data
);

	localparam int LW = $clog2(WORD_BITS);
	localparam int QW = CNT_W - LW;
	localparam int PW = ((AW > QW) ? AW : QW) + 2;

	// bits below k set
	function automatic logic [WORD_BITS-1:0] low_mask(input logic [LW:0] k);
		return ~({WORD_BITS{1'b1}} << k);
	endfunction

	// bits of word a that lie below the count
	function automatic logic [WORD_BITS-1:0] cnt_mask(input logic [AW-1:0] a,
		input logic [CNT_W-1:0] cnt);
		logic [PW-1:0] aw, nw;
		aw = PW'(a);
		nw = PW'(cnt >> LW);
		if (aw < nw) begin
			return {WORD_BITS{1'b1}};
		end else if (aw == nw) begin
			return low_mask({1'b0, cnt[LW-1:0]});
		end else begin
			return '0;
		end
	endfunction

	function automatic logic [LW-1:0] lowest(input logic [WORD_BITS-1:0] v);
		logic [LW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = LW'(i);
		end
		return idx;
	endfunction

	function automatic logic [LW-1:0] highest(input logic [WORD_BITS-1:0] v);
		logic [LW-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) idx = LW'(i);
		end
		return idx;
	endfunction

	state_t state_q, state_d;
	logic [OP_W-1:0]      op_q, op_d;
	logic [CNT_W-1:0]     pos_q, pos_d;
	logic [LW-1:0]        r_q, r_d;
	logic [PW-1:0]        rptr_q, rptr_d, iptr;
	logic [AW:0]          rcnt_q, rcnt_d;
	logic [AW-1:0]        wcnt_q, wcnt_d;
	logic [WORD_BITS-1:0] hold_q, hold_d;
	logic                 have_q, have_d;
	logic                 live_s1, vld_s1;
	logic [AW-1:0]        addr_s1;
	logic                 ok_q, ok_d, val_q, val_d;
	logic [CNT_W-1:0]     found_q, found_d;
	logic                 issue;
	logic [WORD_BITS-1:0] d_s1, m_rd, m_wr, dm, cand, smask;
	logic [PW-1:0]        lastw, dir;
	logic [LW:0]          rinv;
	logic [AW-1:0]        wa;
	logic                 want;

	assign lastw = PW'((n - CNT_W'(1)) >> LW);
	assign d_s1  = vld_s1 ? rd_data : '0;
	assign m_rd  = cnt_mask(addr_s1, n);
	assign rinv  = (LW+1)'(WORD_BITS) - {1'b0, r_q};
	assign wa    = (op_q == OP_SHL) ? (AW'(WORDS - 1) - wcnt_q) : wcnt_q;
	assign m_wr  = cnt_mask(wa, n);
	assign dm    = (op_q == OP_SHR || op_q == OP_SHL) ? (d_s1 & m_rd) : d_s1;
	assign want  = (op_q == OP_NEXT1 || op_q == OP_FIRST1);
	assign smask = (PW'(addr_s1) == PW'(pos_q >> LW)) ? ~low_mask({1'b0, pos_q[LW-1:0]})
		: {WORD_BITS{1'b1}};

	// sequence the operation
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		pos_d   = pos_q;
		r_d     = r_q;
		rptr_d  = rptr_q;
		rcnt_d  = rcnt_q;
		wcnt_d  = wcnt_q;
		hold_d  = hold_q;
		have_d  = have_q;
		ok_d    = ok_q;
		val_d   = val_q;
		found_d = found_q;
		issue   = 1'b0;
		iptr    = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		cand    = '0;
		dir     = (op_q == OP_SHL) ? {PW{1'b1}} : PW'(1);
		case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = wcnt_q;
				wcnt_d  = wcnt_q + AW'(1);
				if (wcnt_q == AW'(WORDS - 1)) begin
					wcnt_d  = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					op_d    = op;
					pos_d   = position;
					r_d     = amount[LW-1:0];
					ok_d    = 1'b1;
					val_d   = 1'b0;
					found_d = '0;
					state_d = S_DONE;
					case (op)
						OP_SET, OP_CLR, OP_CHK: begin
							if (position < n) begin
								issue   = 1'b1;
								iptr    = PW'(position >> LW);
								state_d = S_BIT;
							end else begin
								ok_d = 1'b0;
							end
						end
						OP_NEXT1, OP_NEXT0: begin
							if (position >= n) begin
								found_d = n;
							end else begin
								issue   = 1'b1;
								iptr    = PW'(position >> LW);
								state_d = S_SRCH;
							end
						end
						OP_FIRST1, OP_FIRST0: begin
							pos_d = '0;
							if (n != '0) begin
								issue   = 1'b1;
								state_d = S_SRCH;
							end
						end
						OP_LAST1: begin
							if (n != '0) begin
								issue   = 1'b1;
								iptr    = lastw;
								state_d = S_LAST;
							end
						end
						OP_SETALL, OP_CLRALL, OP_SHR, OP_SHL: begin
							if (n != '0) begin
								issue   = 1'b1;
								rcnt_d  = (AW+1)'(1);
								wcnt_d  = '0;
								have_d  = 1'b0;
								state_d = S_STRM;
								if (op == OP_SHL) begin
									iptr   = PW'(WORDS - 1) - PW'(amount >> LW);
									rptr_d = iptr - PW'(1);
								end else begin
									if (op == OP_SHR) iptr = PW'(amount >> LW);
									rptr_d = iptr + PW'(1);
								end
							end
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
				end
			end
			S_BIT: begin
				state_d = S_DONE;
				if (op_q == OP_CHK) begin
					val_d = d_s1[pos_q[LW-1:0]];
				end else begin
					wr_en   = 1'b1;
					wr_addr = addr_s1;
					wr_data = d_s1;
					wr_data[pos_q[LW-1:0]] = (op_q == OP_SET);
				end
			end
			S_SRCH: begin
				cand = (want ? d_s1 : ~d_s1) & m_rd & smask;
				if (cand != '0) begin
					found_d = CNT_W'({addr_s1, lowest(cand)});
					state_d = S_DONE;
				end else if (PW'(addr_s1) == lastw) begin
					found_d = n;
					state_d = S_DONE;
				end else begin
					issue = 1'b1;
					iptr  = PW'(addr_s1) + PW'(1);
				end
			end
			S_LAST: begin
				cand = d_s1 & m_rd;
				if (cand != '0) begin
					found_d = CNT_W'({addr_s1, highest(cand)});
					state_d = S_DONE;
				end else if (addr_s1 == '0) begin
					found_d = n;
					state_d = S_DONE;
				end else begin
					issue = 1'b1;
					iptr  = PW'(addr_s1) - PW'(1);
				end
			end
			S_STRM: begin
				// stream reads ahead of writes
				if (rcnt_q <= (AW+1)'(WORDS)) begin
					issue  = 1'b1;
					iptr   = rptr_q;
					rptr_d = rptr_q + dir;
					rcnt_d = rcnt_q + (AW+1)'(1);
				end
				if (live_s1) begin
					hold_d = dm;
					have_d = 1'b1;
					if (have_q) begin
						wr_en   = 1'b1;
						wr_addr = wa;
						wcnt_d  = wcnt_q + AW'(1);
						case (op_q)
							OP_SHR:  wr_data = ((hold_q >> r_q) | (dm << rinv)) & m_wr;
							OP_SHL:  wr_data = ((hold_q << r_q) | (dm >> rinv)) & m_wr;
							OP_SETALL: wr_data = hold_q | m_wr;
							default: wr_data = hold_q & ~m_wr;
						endcase
						if (wcnt_q == AW'(WORDS - 1)) begin
							wcnt_d  = '0;
							state_d = S_DONE;
						end
					end
				end
			end
			S_DONE: begin
				if (take) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rd_en   = issue && !iptr[PW-1] && (iptr < PW'(WORDS));
	assign rd_addr = iptr[AW-1:0];

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			wcnt_q  <= '0;
			rcnt_q  <= '0;
			have_q  <= 1'b0;
			live_s1 <= 1'b0;
			vld_s1  <= 1'b0;
			op_q    <= '0;
		end else begin
			state_q <= state_d;
			wcnt_q  <= wcnt_d;
			rcnt_q  <= rcnt_d;
			have_q  <= have_d;
			live_s1 <= issue;
			vld_s1  <= rd_en;
			op_q    <= op_d;
		end
	end

	// hold operands, word data and result
	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		r_q     <= r_d;
		rptr_q  <= rptr_d;
		hold_q  <= hold_d;
		addr_s1 <= rd_addr;
		ok_q    <= ok_d;
		val_q   <= val_d;
		found_q <= found_d;
	end

	assign idle        = (state_q == S_IDLE);
	assign done        = (state_q == S_DONE);
	assign ok          = ok_q;
	assign bit_value   = val_q;
	assign found_index = found_q;

endmodule

>>> sv/bitmap_search_engine.sv
// Bitmap search engine top level: count register, sequencer, word store, result register.
//
//  channel | role | carries
//  req     | sink   | op, position, amount
//  rsp     | source | ok, bit_value, found_index
//  cfg     | sink   | data (bit count)
//
// Set, clear and check read the word that holds the position, then write it back or
// sample the bit; an out-of-range position goes straight to the result. Searches read
// word after word until a hit or the last word; fills and shifts stream every word
// through the single read and write port of the store. Undefined ops and searches that
// need no read go straight to the result. After reset a clearing pass zeroes the store;
// req is not ready during it. A new item is taken while a result waits in rsp.
module bitmap_search_engine import bse_pkg::*; #(
	parameter int MAX_BITS  = MAX_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	bse_req_if.sink     req,
	bse_rsp_if.source   rsp,
	bse_cfg_if.sink     cfg
);

	localparam int WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [CNT_W-1:0]     bit_count_q, n;
	logic                 idle, done, take, free, start;
	logic                 res_ok, res_val;
	logic [CNT_W-1:0]     res_found;
	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [WORD_BITS-1:0] wr_data, rd_data;
	logic                 out_valid_q;

	// hold the bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= CNT_W'(COUNT_RESET);
		end else if (cfg.valid) begin
			bit_count_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;
	assign n = (int'(bit_count_q) > MAX_BITS) ? CNT_W'(MAX_BITS) : bit_count_q;

	assign req.ready = idle;
	assign start     = req.valid && idle;
	assign free      = !out_valid_q || rsp.ready;
	assign take      = done && free;

	bse_seq #(.MAX_BITS(MAX_BITS), .WORD_BITS(WORD_BITS)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .op(req.op),
		.position(req.position), .amount(req.amount), .n(n),
		.idle(idle), .done(done), .take(take),
		.ok(res_ok), .bit_value(res_val), .found_index(res_found),
		.rd_en(rd_en), .rd_addr(rd_addr), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(wr_data), .rd_data(rd_data)
	);

	bse_mem #(.WORDS(WORDS), .WIDTH(WORD_BITS), .AW(AW)) u_mem (
		.clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .wr_en(wr_en),
		.wr_addr(wr_addr), .wr_data(wr_data), .rd_data(rd_data)
	);

	// hold the result item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp.ok          <= res_ok;
			rsp.bit_value   <= res_val;
			rsp.found_index <= res_found;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule
